// File: rtl/core/mrd_pkg.sv
package mrd_pkg;

   // default sizes
   localparam int RING_DEPTH_DEF = 512;
   localparam int WORD_DEPTH_DEF = 128;

   // protocol constants
   localparam logic [7:0]  ADDR_RESET        = 8'h01;
   localparam int          MIN_HELD          = 6;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  FN_READ_HOLDING   = 8'h03;
   localparam logic [7:0]  FN_WRITE_SINGLE   = 8'h06;
   localparam logic [7:0]  FN_WRITE_MULTIPLE = 8'h10;
   localparam int          LEN_EXTRA_READ    = 5;
   localparam int          LEN_WRITE_SINGLE  = 8;
   localparam int          LEN_WRITE_MULTI   = 16;

   // frame offset width: longest frame is 255 + 5 bytes
   localparam int OFS_W = 9;

   // item commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
      logic [6:0] word_index;
   } req_type;

   typedef struct packed {
      logic        frame_accepted;
      logic [7:0]  func_code;
      logic [7:0]  byte_count;
      logic [15:0] word_value;
      logic        overflow;
   } rsp_type;

   // classified item handed from front to engine
   typedef struct packed {
      logic    valid;
      logic    is_push;
      req_type req;
   } fe_item_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_CHECK,
      E_HDR_RD,
      E_HDR_DATA,
      E_EVAL,
      E_CRC_RD,
      E_CRC_DATA,
      E_UNP_RD,
      E_UNP_DATA,
      E_COMMIT,
      E_WORD_RD,
      E_WORD_DATA,
      E_DONE
   } eng_state_type;

   // one byte of crc-16/modbus
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/mrd_ram.sv
module mrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/mrd_front.sv
module mrd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  mrd_pkg::req_type     req_data,
   output logic                 req_full,
   input  logic                 take,
   output mrd_pkg::fe_item_type item
);

   mrd_pkg::req_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign req_full = (count_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = take && (count_ff != 2'd0);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

   // classify the oldest item
   always_comb begin
      item.valid   = (count_ff != 2'd0);
      item.req     = slot_ff[rd_ptr_ff];
      item.is_push = (slot_ff[rd_ptr_ff].cmd == mrd_pkg::CMD_PUSH);
   end

endmodule

// File: rtl/core/mrd_engine.sv
module mrd_engine #(
   parameter int RING_DEPTH = mrd_pkg::RING_DEPTH_DEF,
   parameter int WORD_DEPTH = mrd_pkg::WORD_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  mrd_pkg::fe_item_type item,
   output logic                 take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output mrd_pkg::rsp_type     rsp_data
);

   localparam int RAW = $clog2(RING_DEPTH);
   localparam int HW  = $clog2(RING_DEPTH + 1);
   localparam int WAW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
   localparam int OW  = mrd_pkg::OFS_W;

   mrd_pkg::eng_state_type state_ff, state_in;

   logic [RAW-1:0]        head_ff, head_in;
   logic [RAW-1:0]        tail_ff, tail_in;
   logic [HW-1:0]         held_ff, held_in;
   logic [OW-1:0]         k_ff, k_in;
   logic [OW-1:0]         len_ff, len_in;
   logic [7:0]            addr_b_ff, addr_b_in;
   logic [7:0]            fn_ff, fn_in;
   logic [7:0]            cnt_ff, cnt_in;
   logic [15:0]           crc_ff, crc_in;
   logic                  lo_ok_ff, lo_ok_in;
   logic [7:0]            hi_ff, hi_in;
   logic [7:0]            w_ff, w_in;
   logic [6:0]            idx_ff, idx_in;
   logic [7:0]            last_func_ff, last_func_in;
   logic [7:0]            last_count_ff, last_count_in;
   logic                  acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [15:0]           word_ff, word_in;
   logic [7:0]            slave_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   mrd_pkg::rsp_type      rsp_ff, rsp_in;
   logic [WORD_DEPTH-1:0] wvalid_ff, wvalid_in;

   logic                  ring_we;
   logic [RAW-1:0]        ring_rd_addr;
   logic [7:0]            ring_rd;
   logic                  word_we;
   logic [15:0]           word_rd;
   logic                  drop_en;
   logic [OW-1:0]         drop_amt;
   logic [RAW:0]          peek_sum;
   logic [RAW:0]          tail_sum;
   logic                  hdr_ok;
   logic [OW-1:0]         len_calc;
   logic                  unp_end;

   assign take = (state_ff == mrd_pkg::E_IDLE) && item.valid && !rsp_valid_ff;

   // peek address: tail plus offset, wrapped once
   always_comb begin
      peek_sum = {1'b0, tail_ff} + (RAW + 1)'(k_ff);
      if (peek_sum >= (RAW + 1)'(RING_DEPTH)) begin
         peek_sum = peek_sum - (RAW + 1)'(RING_DEPTH);
      end
      ring_rd_addr = peek_sum[RAW-1:0];
   end

   // header decode and frame length
   always_comb begin
      hdr_ok = (addr_b_ff == slave_ff) &&
               ((fn_ff == mrd_pkg::FN_READ_HOLDING) ||
                (fn_ff == mrd_pkg::FN_WRITE_SINGLE) ||
                (fn_ff == mrd_pkg::FN_WRITE_MULTIPLE));
      if (fn_ff == mrd_pkg::FN_READ_HOLDING) begin
         len_calc = OW'(cnt_ff) + OW'(mrd_pkg::LEN_EXTRA_READ);
      end else if (fn_ff == mrd_pkg::FN_WRITE_SINGLE) begin
         len_calc = OW'(mrd_pkg::LEN_WRITE_SINGLE);
      end else begin
         len_calc = OW'(mrd_pkg::LEN_WRITE_MULTI);
      end
      unp_end = k_ff[0] && ((w_ff == {1'b0, cnt_ff[7:1]}) || (w_ff >= 8'(WORD_DEPTH)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrd_pkg::E_IDLE: begin
            if (take) begin
               state_in = item.is_push ? mrd_pkg::E_CHECK : mrd_pkg::E_WORD_RD;
            end
         end
         mrd_pkg::E_CHECK: begin
            state_in = (held_ff < HW'(mrd_pkg::MIN_HELD)) ? mrd_pkg::E_DONE
                                                          : mrd_pkg::E_HDR_RD;
         end
         mrd_pkg::E_HDR_RD:   state_in = mrd_pkg::E_HDR_DATA;
         mrd_pkg::E_HDR_DATA: begin
            state_in = (k_ff == OW'(2)) ? mrd_pkg::E_EVAL : mrd_pkg::E_HDR_RD;
         end
         mrd_pkg::E_EVAL: begin
            if (!hdr_ok) begin
               state_in = mrd_pkg::E_CHECK;
            end else if (held_ff < HW'(len_calc)) begin
               state_in = mrd_pkg::E_DONE;
            end else begin
               state_in = mrd_pkg::E_CRC_RD;
            end
         end
         mrd_pkg::E_CRC_RD:   state_in = mrd_pkg::E_CRC_DATA;
         mrd_pkg::E_CRC_DATA: begin
            if (k_ff == len_ff - OW'(1)) begin
               if (lo_ok_ff && (ring_rd == crc_ff[15:8])) begin
                  state_in = (fn_ff == mrd_pkg::FN_READ_HOLDING) ? mrd_pkg::E_UNP_RD
                                                                 : mrd_pkg::E_COMMIT;
               end else begin
                  state_in = mrd_pkg::E_CHECK;
               end
            end else begin
               state_in = mrd_pkg::E_CRC_RD;
            end
         end
         mrd_pkg::E_UNP_RD: begin
            state_in = unp_end ? mrd_pkg::E_COMMIT : mrd_pkg::E_UNP_DATA;
         end
         mrd_pkg::E_UNP_DATA:  state_in = mrd_pkg::E_UNP_RD;
         mrd_pkg::E_COMMIT:    state_in = mrd_pkg::E_DONE;
         mrd_pkg::E_WORD_RD:   state_in = mrd_pkg::E_WORD_DATA;
         mrd_pkg::E_WORD_DATA: state_in = mrd_pkg::E_DONE;
         mrd_pkg::E_DONE:      state_in = mrd_pkg::E_IDLE;
         default:              state_in = mrd_pkg::E_IDLE;
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      head_in       = head_ff;
      held_in       = held_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      addr_b_in     = addr_b_ff;
      fn_in         = fn_ff;
      cnt_in        = cnt_ff;
      crc_in        = crc_ff;
      lo_ok_in      = lo_ok_ff;
      hi_in         = hi_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      last_func_in  = last_func_ff;
      last_count_in = last_count_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      word_in       = word_ff;
      wvalid_in     = wvalid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      ring_we       = 1'b0;
      word_we       = 1'b0;
      drop_en       = 1'b0;
      drop_amt      = OW'(1);
      unique case (state_ff)
         mrd_pkg::E_IDLE: begin
            if (take) begin
               acc_in  = 1'b0;
               ovf_in  = 1'b0;
               word_in = 16'h0000;
               idx_in  = item.req.word_index;
               if (item.is_push) begin
                  if (held_ff == HW'(RING_DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     ring_we = 1'b1;
                     head_in = (head_ff == RAW'(RING_DEPTH - 1)) ? '0 : head_ff + RAW'(1);
                     held_in = held_ff + HW'(1);
                  end
               end
            end
         end
         mrd_pkg::E_CHECK: k_in = '0;
         mrd_pkg::E_HDR_RD: ;
         mrd_pkg::E_HDR_DATA: begin
            case (k_ff[1:0])
               2'd0:    addr_b_in = ring_rd;
               2'd1:    fn_in     = ring_rd;
               default: cnt_in    = ring_rd;
            endcase
            k_in = k_ff + OW'(1);
         end
         mrd_pkg::E_EVAL: begin
            if (!hdr_ok) begin
               drop_en = 1'b1;
            end else begin
               len_in = len_calc;
               k_in   = '0;
               crc_in = mrd_pkg::CRC_INIT;
            end
         end
         mrd_pkg::E_CRC_RD: ;
         mrd_pkg::E_CRC_DATA: begin
            k_in = k_ff + OW'(1);
            if (k_ff < len_ff - OW'(2)) begin
               crc_in = mrd_pkg::crc_step(crc_ff, ring_rd);
            end else if (k_ff == len_ff - OW'(2)) begin
               lo_ok_in = (ring_rd == crc_ff[7:0]);
            end else if (lo_ok_ff && (ring_rd == crc_ff[15:8])) begin
               last_func_in = fn_ff;
               if (fn_ff == mrd_pkg::FN_READ_HOLDING) begin
                  last_count_in = cnt_ff;
                  k_in          = OW'(3);
                  w_in          = 8'd0;
               end
            end else begin
               drop_en = 1'b1;
            end
         end
         mrd_pkg::E_UNP_RD: ;
         mrd_pkg::E_UNP_DATA: begin
            k_in = k_ff + OW'(1);
            if (k_ff[0]) begin
               hi_in = ring_rd;
            end else begin
               word_we                 = 1'b1;
               wvalid_in[w_ff[WAW-1:0]] = 1'b1;
               w_in                    = w_ff + 8'd1;
            end
         end
         mrd_pkg::E_COMMIT: begin
            drop_en  = 1'b1;
            drop_amt = len_ff;
            acc_in   = 1'b1;
         end
         mrd_pkg::E_WORD_RD: ;
         mrd_pkg::E_WORD_DATA: begin
            if (({1'b0, idx_ff} < 8'(WORD_DEPTH)) && wvalid_ff[idx_ff[WAW-1:0]]) begin
               word_in = word_rd;
            end
         end
         mrd_pkg::E_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.frame_accepted = acc_ff;
            rsp_in.func_code      = last_func_ff;
            rsp_in.byte_count     = last_count_ff;
            rsp_in.word_value     = word_ff;
            rsp_in.overflow       = ovf_ff;
         end
         default: ;
      endcase
   end

   // ring tail advance on drop
   always_comb begin
      tail_sum = {1'b0, tail_ff} + (RAW + 1)'(drop_amt);
      if (tail_sum >= (RAW + 1)'(RING_DEPTH)) begin
         tail_sum = tail_sum - (RAW + 1)'(RING_DEPTH);
      end
      tail_in = drop_en ? tail_sum[RAW-1:0] : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mrd_pkg::E_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         held_ff       <= '0;
         last_func_ff  <= 8'h00;
         last_count_ff <= 8'h00;
         wvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         slave_ff      <= mrd_pkg::ADDR_RESET;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         held_ff       <= drop_en ? held_in - HW'(drop_amt) : held_in;
         last_func_ff  <= last_func_in;
         last_count_ff <= last_count_in;
         wvalid_ff     <= wvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            slave_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      len_ff    <= len_in;
      addr_b_ff <= addr_b_in;
      fn_ff     <= fn_in;
      cnt_ff    <= cnt_in;
      crc_ff    <= crc_in;
      lo_ok_ff  <= lo_ok_in;
      hi_ff     <= hi_in;
      w_ff      <= w_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      ovf_ff    <= ovf_in;
      word_ff   <= word_in;
      rsp_ff    <= rsp_in;
   end

   mrd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (head_ff),
      .wr_data (item.req.rx_byte),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd)
   );

   mrd_ram #(.WIDTH(16), .DEPTH(WORD_DEPTH)) u_words (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (w_ff[WAW-1:0]),
      .wr_data ({hi_ff, ring_rd}),
      .rd_addr (idx_ff[WAW-1:0]),
      .rd_data (word_rd)
   );

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(RING_DEPTH))
      else $error("held count above ring depth");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, tail_ff} < (RAW + 1)'(RING_DEPTH) && {1'b0, head_ff} < (RAW + 1)'(RING_DEPTH))
      else $error("ring pointer out of range");

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == mrd_pkg::E_DONE |-> !rsp_valid_ff)
      else $error("result produced while slot occupied");

   a_unpack_in_store: assert property (@(posedge clock) disable iff (reset)
      word_we |-> w_ff < 8'(WORD_DEPTH))
      else $error("word write beyond store");

endmodule

// File: rtl/core/modbus_rtu_response_deframer.sv
// Modbus RTU response deframer. Push received bytes (cmd 0) or read a stored
// register word (cmd 1) through the req_ queue; every item yields exactly one
// result on the rsp_ queue. Bytes land in a ring of RING_DEPTH entries; after
// each push the engine rescans from the oldest byte for a frame that starts
// with the csr_ slave address and function 3, 6 or 16, waits for the whole
// frame, checks its CRC-16 and on success unpacks function-3 payload words
// into the word store. A two-entry queue in front keeps taking items while
// the engine works. Cost per push grows with each header tried, each byte of
// each candidate frame run through the CRC and each payload byte unpacked,
// all set by the one read port of the ring memory. The engine starts the
// next item only after the previous result has been popped. There is no
// clearing pass after reset.
module modbus_rtu_response_deframer #(
   parameter int RING_DEPTH = mrd_pkg::RING_DEPTH_DEF,
   parameter int WORD_DEPTH = mrd_pkg::WORD_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  mrd_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mrd_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   mrd_pkg::fe_item_type item;
   logic                 take;

   // front: item queue and classify
   mrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .take     (take),
      .item     (item)
   );

   // back: ring, scan engine, word store, result slot
   mrd_engine #(
      .RING_DEPTH (RING_DEPTH),
      .WORD_DEPTH (WORD_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .take        (take),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: dv/modbus_rtu_response_deframer_test.sv
`timescale 1ns / 1ps

module modbus_rtu_response_deframer_test;

   localparam int RING_SLOTS  = 512;
   localparam int WORD_SLOTS  = 128;
   localparam int PHASE_ITEMS = 100;
   localparam int STALL_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   typedef logic [7:0] octet_list_type[$];

   typedef struct {
      mrd_pkg::req_type item;
      bit               typed;
      mrd_pkg::rsp_type want;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   mrd_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   mrd_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [7:0]       csr_wr_data = '0;

   // frame decoder mirror
   logic [7:0]  rx_bytes[$];
   logic [15:0] reg_words[WORD_SLOTS];
   logic [7:0]  last_fn;
   logic [7:0]  last_cnt;
   logic [7:0]  slave_addr;

   mrd_pkg::rsp_type pending_rsp[$];
   int          mismatch_count = 0;
   int          stall_cycles = 0;
   int          send_idle = 35;
   int          recv_idle = 51;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;

   modbus_rtu_response_deframer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // crc-16/modbus over the first n bytes
   function automatic logic [15:0] modbus_crc(octet_list_type b, int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         c = c ^ {8'h00, b[i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
      end
      return c;
   endfunction

   // expected result of one item, updates the mirror state
   function automatic mrd_pkg::rsp_type predict(mrd_pkg::req_type r);
      mrd_pkg::rsp_type o;
      int          len;
      bit          hit;
      logic [7:0]  fn;
      logic [15:0] c;
      o = '0;
      if (r.cmd == mrd_pkg::CMD_PUSH) begin
         if (rx_bytes.size() >= RING_SLOTS) begin
            o.overflow = 1'b1;
         end else begin
            rx_bytes.push_back(r.rx_byte);
         end
         hit = 1'b0;
         while (!hit && rx_bytes.size() >= mrd_pkg::MIN_HELD) begin
            fn = rx_bytes[1];
            if (rx_bytes[0] != slave_addr || !(fn == mrd_pkg::FN_READ_HOLDING ||
                fn == mrd_pkg::FN_WRITE_SINGLE || fn == mrd_pkg::FN_WRITE_MULTIPLE)) begin
               void'(rx_bytes.pop_front());
               continue;
            end
            if (fn == mrd_pkg::FN_READ_HOLDING) len = int'(rx_bytes[2]) + mrd_pkg::LEN_EXTRA_READ;
            else if (fn == mrd_pkg::FN_WRITE_SINGLE) len = mrd_pkg::LEN_WRITE_SINGLE;
            else len = mrd_pkg::LEN_WRITE_MULTI;
            if (rx_bytes.size() < len) break;
            c = modbus_crc(rx_bytes, len - 2);
            if (rx_bytes[len-2] != c[7:0] || rx_bytes[len-1] != c[15:8]) begin
               void'(rx_bytes.pop_front());
               continue;
            end
            last_fn = fn;
            if (fn == mrd_pkg::FN_READ_HOLDING) begin
               last_cnt = rx_bytes[2];
               for (int i = 0; i < int'(rx_bytes[2]) / 2; i++) begin
                  if (i < WORD_SLOTS) reg_words[i] = {rx_bytes[3+2*i], rx_bytes[4+2*i]};
               end
            end
            repeat (len) void'(rx_bytes.pop_front());
            hit = 1'b1;
         end
         o.frame_accepted = hit;
      end else begin
         o.word_value = reg_words[r.word_index];
      end
      o.func_code  = last_fn;
      o.byte_count = last_cnt;
      return o;
   endfunction

   // address, function, body, crc low then high
   function automatic void add_frame(ref octet_list_type q, input logic [7:0] addr,
                                     input logic [7:0] fn, input octet_list_type body);
      octet_list_type f;
      logic [15:0] c;
      f = body;
      f.push_front(fn);
      f.push_front(addr);
      c = modbus_crc(f, f.size());
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      foreach (f[i]) q.push_back(f[i]);
   endfunction

   function automatic mrd_pkg::req_type push_item(logic [7:0] b);
      mrd_pkg::req_type r;
      r.cmd        = mrd_pkg::CMD_PUSH;
      r.rx_byte    = b;
      r.word_index = 7'($urandom);
      return r;
   endfunction

   function automatic mrd_pkg::req_type read_item(logic [6:0] idx);
      mrd_pkg::req_type r;
      r.cmd        = mrd_pkg::CMD_READ;
      r.rx_byte    = 8'($urandom);
      r.word_index = idx;
      return r;
   endfunction

   // one random burst: mostly well-formed frames, some broken ones, noise, reads
   function automatic void add_burst(ref mrd_pkg::req_type q[$]);
      octet_list_type b, body;
      int          pick, n;
      logic [7:0]  fn;
      pick = $urandom_range(99);
      if (pick >= 85) begin
         q.push_back(read_item($urandom_range(1) ? 7'($urandom_range(9)) : 7'($urandom)));
         return;
      end
      if (pick >= 78) begin
         repeat ($urandom_range(1, 6)) b.push_back(8'($urandom));
      end else begin
         case ($urandom_range(2))
            0: begin
               fn = mrd_pkg::FN_READ_HOLDING;
               n = ($urandom_range(9) == 0) ? $urandom_range(17, 255) : $urandom_range(16);
               body.push_back(8'(n));
               repeat (n) body.push_back(8'($urandom));
            end
            1: begin
               fn = mrd_pkg::FN_WRITE_SINGLE;
               repeat (4) body.push_back(8'($urandom));
            end
            default: begin
               fn = mrd_pkg::FN_WRITE_MULTIPLE;
               repeat (12) body.push_back(8'($urandom));
            end
         endcase
         add_frame(b, (pick >= 70) ? (slave_addr ^ 8'($urandom_range(1, 255))) : slave_addr,
                   fn, body);
         // corrupted crc or payload
         if (pick >= 60 && pick < 70) begin
            n = $urandom_range(b.size() - 1);
            b[n] = b[n] ^ 8'($urandom_range(1, 255));
         end
         // truncated frame
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, b.size() - 1)) void'(b.pop_back());
         end
      end
      foreach (b[i]) q.push_back(push_item(b[i]));
   endfunction

   // offer one item until taken, record its expected result
   task automatic send(input mrd_pkg::req_type r, input bit typed,
                       input mrd_pkg::rsp_type want);
      mrd_pkg::rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      p = predict(r);
      pending_rsp.push_back(typed ? want : p);
      @(negedge clock);
   endtask

   // stop offering and wait for every result
   task automatic drain();
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_addr(input logic [7:0] a);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      slave_addr = a;
   endtask

   // receiver side, with one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left--;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      mrd_pkg::rsp_type want;
      if (rsp_pop && !rsp_empty) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item: %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.frame_accepted !== want.frame_accepted ||
                rsp_data.func_code !== want.func_code ||
                rsp_data.byte_count !== want.byte_count ||
                rsp_data.word_value !== want.word_value ||
                rsp_data.overflow !== want.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected acc=%0d fn=%h cnt=%h word=%h ovf=%0d",
                           want.frame_accepted, want.func_code, want.byte_count,
                           want.word_value, want.overflow);
                  $display("          actual   acc=%0d fn=%h cnt=%h word=%h ovf=%0d",
                           rsp_data.frame_accepted, rsp_data.func_code,
                           rsp_data.byte_count, rsp_data.word_value, rsp_data.overflow);
               end
            end
         end
      end
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      plan_row_type     plan[$];
      plan_row_type     row;
      octet_list_type   b, body;
      mrd_pkg::req_type items[$];
      logic [7:0]       addrs[6];
      mrd_pkg::rsp_type none;

      foreach (reg_words[i]) reg_words[i] = '0;
      last_fn    = '0;
      last_cnt   = '0;
      slave_addr = mrd_pkg::ADDR_RESET;
      none       = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reads after reset, noise, odd-count read frame, write frame
      row.typed = 1'b1;
      row.want  = '0;
      row.item  = read_item(7'd0);
      plan.push_back(row);
      row.item  = read_item(7'd127);
      plan.push_back(row);
      row.typed = 1'b0;
      b = {8'h00, 8'hFF};
      body = {8'h03, 8'h12, 8'h34, 8'h56};
      add_frame(b, mrd_pkg::ADDR_RESET, mrd_pkg::FN_READ_HOLDING, body);
      foreach (b[i]) begin
         row.item = push_item(b[i]);
         plan.push_back(row);
      end
      row.typed = 1'b1;
      row.item  = read_item(7'd0);
      row.want  = '{frame_accepted: 1'b0, func_code: mrd_pkg::FN_READ_HOLDING,
                    byte_count: 8'd3, word_value: 16'h1234, overflow: 1'b0};
      plan.push_back(row);
      row.typed = 1'b0;
      b.delete();
      body = {8'h00, 8'h7F, 8'hFF, 8'h80};
      add_frame(b, mrd_pkg::ADDR_RESET, mrd_pkg::FN_WRITE_SINGLE, body);
      foreach (b[i]) begin
         row.item = push_item(b[i]);
         plan.push_back(row);
      end
      row.item = read_item(7'd127);
      plan.push_back(row);
      foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].want);
      drain();

      // random phases across address settings and idle patterns
      addrs = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), mrd_pkg::ADDR_RESET,
                8'($urandom)};
      for (int p = 0; p < 6; p++) begin
         write_addr(addrs[p]);
         case (p / 2)
            0: begin send_idle = 35; recv_idle = 51; end
            1: begin send_idle = 51; recv_idle = 35; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (p == 2) hold_req = 1'b1;
         items.delete();
         while (items.size() < PHASE_ITEMS) add_burst(items);
         foreach (items[i]) send(items[i], 1'b0, none);
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
